@@ rtl/core/mks_pkg.sv @@
// Package with the shared types, character codes and entity decoder of the markup stripper.
`timescale 1ns / 1ps
package mks_pkg;

	localparam int WIN_DEPTH = 5;
	localparam int ENT_DEPTH = 5;
	localparam int RES_SLOTS = 5;
	localparam int EXT_LEN   = 2 * WIN_DEPTH;

	localparam logic [2:0] ENT_OVER = 3'd6;

	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_APOS = 8'h27;

	localparam logic [31:0] TAG_IMG_LC = "<img";
	localparam logic [31:0] TAG_IMG_UC = "<IMG";
	localparam logic [31:0] TAG_BR_LC  = "<br>";
	localparam logic [31:0] TAG_BR_UC  = "<BR>";
	localparam logic [31:0] TAG_BRS_LC = "<br/";
	localparam logic [31:0] TAG_BRS_UC = "<BR/";
	localparam logic [31:0] TAG_P_LC   = "</p>";
	localparam logic [31:0] TAG_P_UC   = "</P>";

	localparam logic [15:0] ENT_LT   = "lt";
	localparam logic [15:0] ENT_GT   = "gt";
	localparam logic [23:0] ENT_AMP  = "amp";
	localparam logic [23:0] ENT_NL10 = "#10";
	localparam logic [23:0] ENT_NL13 = "#13";
	localparam logic [31:0] ENT_NBSP = "nbsp";
	localparam logic [31:0] ENT_QUOT = "quot";
	localparam logic [31:0] ENT_APOS = "apos";

	typedef struct packed {
		logic [7:0] in_char;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       run_last;
		logic       text_end;
	} out_item_t;

	typedef out_item_t [RES_SLOTS-1:0] res_batch_t;

	// Control state of the parser; all of it is cleared by reset.
	typedef struct packed {
		logic [2:0] window_fill;
		logic       inside_tag;
		logic       skipping_image;
		logic       inside_entity;
		logic [2:0] entity_length;
	} mks_ctrl_t;

	// Byte stores; entries are only read after they have been written.
	typedef struct packed {
		logic [WIN_DEPTH-1:0][7:0] window;
		logic [ENT_DEPTH-1:0][7:0] entity_bytes;
	} mks_data_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] ch;
	} ent_hit_t;

	// Looks up a buffered entity name; element 0 holds the first byte after the ampersand.
	function automatic ent_hit_t ent_decode(input logic [ENT_DEPTH-1:0][7:0] b,
	                                        input logic [2:0] len);
		ent_hit_t r;
		r = '0;
		case (len)
			3'd2: begin
				if ({b[0], b[1]} == ENT_LT) r = '{hit: 1'b1, ch: CH_LT};
				else if ({b[0], b[1]} == ENT_GT) r = '{hit: 1'b1, ch: CH_GT};
			end
			3'd3: begin
				if ({b[0], b[1], b[2]} == ENT_AMP) r = '{hit: 1'b1, ch: CH_AMP};
				else if ({b[0], b[1], b[2]} == ENT_NL10) r = '{hit: 1'b1, ch: CH_NL};
				else if ({b[0], b[1], b[2]} == ENT_NL13) r = '{hit: 1'b1, ch: CH_NL};
			end
			3'd4: begin
				if ({b[0], b[1], b[2], b[3]} == ENT_NBSP) r = '{hit: 1'b1, ch: CH_SP};
				else if ({b[0], b[1], b[2], b[3]} == ENT_QUOT) r = '{hit: 1'b1, ch: CH_QUOT};
				else if ({b[0], b[1], b[2], b[3]} == ENT_APOS) r = '{hit: 1'b1, ch: CH_APOS};
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/mks_chan_if.sv @@
// Valid/ready stream channel carrying one payload of a chosen type.
`timescale 1ns / 1ps
interface mks_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/core/mks_step.sv @@
// Combinational parser step: consumes one byte and produces the next state and its results.
`timescale 1ns / 1ps
module mks_step import mks_pkg::*; (
	input  in_item_t   item,
	input  mks_ctrl_t  ctrl,
	input  mks_data_t  data,
	output mks_ctrl_t  ctrl_nx,
	output mks_data_t  data_nx,
	output res_batch_t res,
	output logic [2:0] res_cnt
);

	logic [EXT_LEN-1:0][7:0]   ext;
	logic [WIN_DEPTH-1:0][7:0] nwin;
	logic [ENT_DEPTH-1:0][7:0] ebytes;
	logic [2:0]  fill;
	logic [2:0]  rem;
	logic [2:0]  nfill;
	logic [2:0]  elen;
	logic [2:0]  cnt;
	logic [7:0]  h;
	logic [31:0] tag4;
	logic        tag, skip, ent, stop, have4, have5;
	ent_hit_t    eh;

	always_comb begin
		ext = '0;
		for (int k = 0; k < WIN_DEPTH; k++) begin
			ext[k] = data.window[k];
		end
		fill = (ctrl.window_fill >= 3'(WIN_DEPTH)) ? 3'(WIN_DEPTH - 1) : ctrl.window_fill;
		ext[{1'b0, fill}] = item.in_char;
		fill = fill + 3'd1;

		tag    = ctrl.inside_tag;
		skip   = ctrl.skipping_image;
		ent    = ctrl.inside_entity;
		elen   = ctrl.entity_length;
		ebytes = data.entity_bytes;
		nwin   = data.window;
		nfill  = '0;
		stop   = 1'b0;
		res    = '0;
		cnt    = '0;
		h      = '0;
		rem    = '0;
		tag4   = '0;
		have4  = 1'b0;
		have5  = 1'b0;
		eh     = '0;

		// Walk the window from its head; a tag opener without enough bytes behind it stops the walk.
		for (int i = 0; i < WIN_DEPTH; i++) begin
			if (!stop && (3'(i) < fill)) begin
				h     = ext[i];
				rem   = fill - 3'(i);
				tag4  = {ext[i], ext[i+1], ext[i+2], ext[i+3]};
				have4 = rem >= 3'd4;
				have5 = rem >= 3'(WIN_DEPTH);
				if (h == CH_LT && !skip && !ent) begin
					if (rem < 3'(WIN_DEPTH) && !item.is_last) begin
						stop  = 1'b1;
						nfill = rem;
						for (int k = 0; k < WIN_DEPTH; k++) begin
							nwin[k] = ext[i+k];
						end
					end else if (have5 && (tag4 == TAG_IMG_LC || tag4 == TAG_IMG_UC)) begin
						skip = 1'b1;
					end else begin
						if (have4 && (tag4 == TAG_BR_LC || tag4 == TAG_BR_UC ||
						              tag4 == TAG_BRS_LC || tag4 == TAG_BRS_UC)) begin
							if (cnt < 3'(RES_SLOTS)) begin
								res[cnt].out_char   = CH_NL;
								res[cnt].char_valid = 1'b1;
							end
							cnt = cnt + 3'd1;
						end
						if (have4 && (tag4 == TAG_P_LC || tag4 == TAG_P_UC)) begin
							for (int n = 0; n < 2; n++) begin
								if (cnt < 3'(RES_SLOTS)) begin
									res[cnt].out_char   = CH_NL;
									res[cnt].char_valid = 1'b1;
								end
								cnt = cnt + 3'd1;
							end
						end
						tag = 1'b1;
					end
				end else if (skip) begin
					if (h == CH_GT) skip = 1'b0;
				end else if (ent) begin
					if (h == CH_SEMI) begin
						eh = ent_decode(ebytes, elen);
						if (eh.hit) begin
							if (cnt < 3'(RES_SLOTS)) begin
								res[cnt].out_char   = eh.ch;
								res[cnt].char_valid = 1'b1;
							end
							cnt = cnt + 3'd1;
						end
						ent  = 1'b0;
						elen = '0;
					end else if (elen < 3'(ENT_DEPTH)) begin
						ebytes[elen] = h;
						elen = elen + 3'd1;
					end else begin
						elen = ENT_OVER;
					end
				end else if (h == CH_AMP) begin
					ent  = 1'b1;
					elen = '0;
				end else if (h == CH_GT) begin
					tag = 1'b0;
				end else if (!tag) begin
					if (cnt < 3'(RES_SLOTS)) begin
						res[cnt].out_char   = h;
						res[cnt].char_valid = 1'b1;
					end
					cnt = cnt + 3'd1;
				end
			end
		end

		if (item.is_last) begin
			if (cnt == 3'd0) begin
				res[0].out_char   = '0;
				res[0].char_valid = 1'b0;
				cnt = 3'd1;
			end
			res[cnt - 3'd1].text_end = 1'b1;
			ctrl_nx = '0;
		end else begin
			ctrl_nx.window_fill    = stop ? nfill : 3'd0;
			ctrl_nx.inside_tag     = tag;
			ctrl_nx.skipping_image = skip;
			ctrl_nx.inside_entity  = ent;
			ctrl_nx.entity_length  = elen;
		end
		if (cnt != 3'd0) begin
			res[cnt - 3'd1].run_last = 1'b1;
		end

		data_nx.window       = nwin;
		data_nx.entity_bytes = ebytes;
		res_cnt              = cnt;
	end

endmodule

@@ rtl/core/markup_stripper.sv @@
// Top level of the streaming markup stripper with entity decoding.
`timescale 1ns / 1ps
// Usage:
// Text enters on the raw channel one byte per transaction, with is_last set on the final
// byte of a text. Stripped bytes leave on the stripped channel, one result per transaction.
// Tags are removed, entities are decoded, and line-break and paragraph tags become newlines.
// A byte may cause zero results (it waits in the lookahead window or is dropped), or up to
// three. The final byte of a text always causes at least one result; text_end marks the last
// result of the text, run_last the last result caused by one input byte.
// Path: an accepted byte is held in the input register and parsed once the result buffer is
// empty or hands over its last result; its results are then registered into the result
// buffer, and entry 0 is offered on the stripped channel.
// Throughput: one input byte per cycle while each byte causes at most one result and the
// receiver keeps ready high. The result buffer drains one result per cycle while ready is
// high, so a byte that causes more results keeps the next byte waiting in the input register
// until its last result leaves; a paragraph end gives two newlines. A byte with no result does not stall.
// Stalls: when the receiver holds ready low, the buffered results stay put, the input
// register fills and raw.ready falls; nothing is lost.
// Reset: arst_n clears the parser control state, the input valid flag and the result count at once.
module markup_stripper import mks_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	mks_chan_if.sink      raw,
	mks_chan_if.source    stripped
);

	// Input register stage.
	in_item_t   item_s1;
	logic       valid_s1;

	// Parser state.
	mks_ctrl_t  ctrl_q;
	mks_data_t  data_q;
	mks_ctrl_t  ctrl_nx;
	mks_data_t  data_nx;

	// Result buffer: entry 0 is the result on offer; it shifts down as results leave.
	res_batch_t batch_q;
	logic [2:0] cnt_q;
	res_batch_t step_res;
	logic [2:0] step_cnt;

	logic pop;
	logic fire;
	logic raw_take;

	mks_step u_step (
		.item    (item_s1),
		.ctrl    (ctrl_q),
		.data    (data_q),
		.ctrl_nx (ctrl_nx),
		.data_nx (data_nx),
		.res     (step_res),
		.res_cnt (step_cnt)
	);

	assign pop  = stripped.valid && stripped.ready;
	// The buffered byte is parsed once the buffer is empty or hands over its last result now.
	assign fire = valid_s1 && ((cnt_q == 3'd0) || (cnt_q == 3'd1 && pop));

	assign raw.ready = !valid_s1 || fire;
	assign raw_take  = raw.valid && raw.ready;

	assign stripped.valid = cnt_q != 3'd0;
	assign stripped.data  = batch_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctrl_q   <= '0;
			cnt_q    <= '0;
		end else begin
			if (raw_take) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				ctrl_q <= ctrl_nx;
				cnt_q  <= step_cnt;
			end else if (pop) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (raw_take) begin
			item_s1 <= raw.data;
		end
		if (fire) begin
			data_q  <= data_nx;
			batch_q <= step_res;
		end else if (pop) begin
			for (int k = 0; k < RES_SLOTS - 1; k++) begin
				batch_q[k] <= batch_q[k+1];
			end
		end
	end

endmodule
